@@ design/epoch_seconds_to_calendar_assert.svh @@
// Assertion macros for the epoch-to-calendar converter.
// Expects signals named clk and rst_n in the including module.
`ifndef EPOCH_SECONDS_TO_CALENDAR_ASSERT_SVH
`define EPOCH_SECONDS_TO_CALENDAR_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define ESC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ESC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
    else $error(msg);

`endif

@@ design/esc_pkg.sv @@
// Shared constants, types and helpers for the epoch-to-calendar converter.
// No dependencies.
`timescale 1ns / 1ps

package esc_pkg;

  // Pipeline depth from accepted start to out_valid.
  localparam int LATENCY = 9;

  localparam logic [0:0]  REG_ZONE_OFFSET = 1'b0;
  localparam logic [4:0]  ZONE_RESET      = 5'd1;

  // 2001-01-01 00:00:00 in Unix seconds (11323 days).
  localparam logic signed [33:0] BASE_SECS = 34'sd978307200;
  localparam logic signed [33:0] SECS_PER_HOUR_S = 34'sd3600;

  localparam logic [11:0] BASE_YEAR = 12'd2001;
  localparam logic [15:0] DAYS_100Y = 16'd36524;
  localparam logic [15:0] DAYS_4Y   = 16'd1461;
  localparam logic [10:0] DAYS_1Y   = 11'd365;

  // Days are t / 86400 = (t >> 7) / 675; the others split the same way.
  localparam logic [24:0] DAY_DIV   = 25'd675;
  localparam logic [16:0] SECS_HOUR = 17'd3600;
  localparam logic [11:0] SECS_MIN  = 12'd60;

  // Reciprocals, exact over the operand ranges used:
  //   x / 675  = (x * RECIP_DAY)  >> 35, x < 2^25
  //   x / 225  = (x * RECIP_HOUR) >> 21, x < 2^13
  //   x / 15   = (x * RECIP_MIN)  >> 14, x < 2^10
  //   x / 1461 = (x * RECIP_4Y)   >> 27, x < 2^16
  localparam logic [25:0] RECIP_DAY  = 26'd50903317;
  localparam logic [13:0] RECIP_HOUR = 14'd9321;
  localparam logic [10:0] RECIP_MIN  = 11'd1093;
  localparam logic [16:0] RECIP_4Y   = 17'd91868;

  localparam logic [8:0] MONTH_START [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } esc_date_t;

  // Day of year on which month m (0 = January) starts.
  function automatic logic [8:0] month_first(logic [3:0] m, logic leap);
    logic [8:0] base;
    base = (m < 4'd12) ? MONTH_START[m] : 9'd0;
    if (leap && m >= 4'd2 && m < 4'd12)
      base = base + 9'd1;
    return base;
  endfunction

  // Zone offset in seconds, with the base date already taken off.
  function automatic logic signed [33:0] zone_bias(logic [4:0] z);
    logic signed [33:0] zs;
    zs = $signed({{29{z[4]}}, z});
    return zs * SECS_PER_HOUR_S - BASE_SECS;
  endfunction

endpackage

@@ design/esc_date_pipe.sv @@
// Day count since 2001-01-01 to Gregorian year, month and day; six stages.
// Depends on esc_pkg.
`timescale 1ns / 1ps

module esc_date_pipe import esc_pkg::*; (
  input  logic        clk,
  input  logic [15:0] days_i,
  output esc_date_t   date_o
);

  // Day counts stay below one 400-year cycle, so the split starts at centuries.

  // stage A: century split (count < two centuries in range)
  logic [1:0]  q100a_r;
  logic [15:0] r100a_r;
  // stage B: 4-year quotient
  logic [32:0] q4_prod;
  logic [4:0]  q4b_r;
  logic [1:0]  q100b_r;
  logic [15:0] r100b_r;
  // stage C: day within the 4-year cycle
  logic [10:0] r4c_r;
  logic [4:0]  q4c_r;
  logic [1:0]  q100c_r;
  // stage D: year and day of year
  logic [1:0]  q1;
  logic [10:0] dd_full;
  logic [8:0]  ddd_r;
  logic [11:0] yeard_r;
  logic        leapd_r;
  // stage E: month index
  logic [3:0]  midx;
  logic [3:0]  midxe_r;
  logic [8:0]  dde_r;
  logic [11:0] yeare_r;
  logic        leape_r;
  logic [8:0]  mstart;

  always_ff @(posedge clk) begin
    if (days_i >= DAYS_100Y) begin
      q100a_r <= 2'd1;
      r100a_r <= days_i - DAYS_100Y;
    end else begin
      q100a_r <= 2'd0;
      r100a_r <= days_i;
    end
  end

  assign q4_prod = 33'(r100a_r) * 33'(RECIP_4Y);

  always_ff @(posedge clk) begin
    q4b_r   <= q4_prod[31:27];
    q100b_r <= q100a_r;
    r100b_r <= r100a_r;
  end

  always_ff @(posedge clk) begin
    r4c_r   <= 11'(r100b_r - 16'(q4b_r) * DAYS_4Y);
    q4c_r   <= q4b_r;
    q100c_r <= q100b_r;
  end

  // Last day of a 4-year cycle stays in the leap year (quotient capped at 3).
  always_comb begin
    q1 = 2'd0;
    if (r4c_r >= 11'd365)  q1 = 2'd1;
    if (r4c_r >= 11'd730)  q1 = 2'd2;
    if (r4c_r >= 11'd1095) q1 = 2'd3;
    dd_full = r4c_r - 11'(q1) * DAYS_1Y;
  end

  // Leap: last year of a 4-year cycle, unless it ends a century that is not
  // the last of a 400-year cycle.
  always_ff @(posedge clk) begin
    ddd_r   <= dd_full[8:0];
    yeard_r <= BASE_YEAR + 12'(q100c_r) * 12'd100 + 12'(q4c_r) * 12'd4 + 12'(q1);
    leapd_r <= (q1 == 2'd3) && ((q4c_r != 5'd24) || (q100c_r == 2'd3));
  end

  always_comb begin
    midx = 4'd0;
    for (int k = 1; k < 12; k++) begin
      if (ddd_r >= month_first(4'(k), leapd_r))
        midx = midx + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    midxe_r <= midx;
    dde_r   <= ddd_r;
    yeare_r <= yeard_r;
    leape_r <= leapd_r;
  end

  assign mstart = month_first(midxe_r, leape_r);

  always_ff @(posedge clk) begin
    date_o.year  <= yeare_r;
    date_o.month <= midxe_r + 4'd1;
    date_o.day   <= 5'(dde_r - mstart) + 5'd1;
  end

endmodule

@@ design/epoch_seconds_to_calendar.sv @@
// Unix seconds to Gregorian date and time of day, top level.
// Depends on esc_pkg, esc_date_pipe and epoch_seconds_to_calendar_assert.svh.
`timescale 1ns / 1ps
`include "epoch_seconds_to_calendar_assert.svh"

// Usage
//   Input: drive in_epoch_seconds / in_micro_seconds and pulse start; a beat
//   is taken at every edge with start high and busy low. busy never rises,
//   so a new timestamp may be issued every cycle.
//   Output: out_valid is high for exactly one cycle per taken beat, in issue
//   order, with all out_* fields valid in that cycle. The receiver has no
//   back-pressure and must take it then.
//   Throughput: one conversion per clock; the pipeline depth is set by the
//   stage count of the divide-by-constant chain (days, then hours,
//   minutes, seconds; in parallel century, 4-year, year and month splits).
//   Times before 2001-01-01 after the zone offset set out_before_base and
//   zero the calendar fields; microseconds always pass through.
//   Config: APB register 0 (byte address 0) holds the signed 5-bit zone
//   offset in hours. Write it only while no conversion is in flight.
//   Reset (rst_n low, synchronous) empties the pipeline and sets the offset
//   to +1 hour; there is no clearing pass, the block is ready the next cycle.

module epoch_seconds_to_calendar import esc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_epoch_seconds,
  input  logic [19:0] in_micro_seconds,
  // result channel
  output logic        out_valid,
  output logic [11:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_second,
  output logic [19:0] out_micro_out,
  output logic        out_before_base,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic accept;
  logic cfg_wr;

  logic [4:0]         zone_r;
  logic signed [33:0] bias_r;   // offset*3600 - base, ready before the add

  logic [LATENCY-1:0] valid_r;
  logic [19:0]        micro_r [1:8];
  logic               neg_r   [1:8];

  // seconds pipeline
  logic signed [33:0] diff;
  logic [31:0] t1_r;
  logic [50:0] day_prod;
  logic [15:0] ad2_r;
  logic [24:0] u2_r;
  logic [6:0]  lo2_r;
  logic [24:0] rem675;
  logic [16:0] sod3_r;
  logic [26:0] hour_prod;
  logic [4:0]  hour4_r, hour5_r, hour6_r, hour7_r, hour8_r;
  logic [16:0] sod4_r;
  logic [11:0] soh5_r, soh6_r;
  logic [20:0] min_prod;
  logic [5:0]  min6_r, min7_r, min8_r;
  logic [5:0]  sec7_r, sec8_r;
  esc_date_t   date8;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign pready = 1'b1;

  // ---------------------------------------------------------------- config
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_ZONE_OFFSET);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_r <= ZONE_RESET;
      bias_r <= zone_bias(ZONE_RESET);
    end else if (cfg_wr) begin
      zone_r <= pwdata[4:0];
      bias_r <= zone_bias(pwdata[4:0]);
    end
  end

  assign prdata = (paddr[2] == REG_ZONE_OFFSET) ? {27'd0, zone_r} : 32'd0;

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (!rst_n)
      valid_r <= '0;
    else
      valid_r <= {valid_r[LATENCY-2:0], accept};
  end

  assign out_valid = valid_r[LATENCY-1];

  // sideband: microseconds and the before-base flag ride along
  always_ff @(posedge clk) begin
    micro_r[1] <= in_micro_seconds;
    neg_r[1]   <= diff[33];
    for (int i = 2; i <= 8; i++) begin
      micro_r[i] <= micro_r[i-1];
      neg_r[i]   <= neg_r[i-1];
    end
  end

  // ---------------------------------------------------------------- stage 1
  // Seconds since 2001-01-01 in local time; negative means before base.
  assign diff = $signed({2'b00, in_epoch_seconds}) + bias_r;

  always_ff @(posedge clk) begin
    t1_r <= diff[31:0];
  end

  // ---------------------------------------------------------------- stage 2
  // Day count: (t >> 7) / 675.
  assign day_prod = 51'(t1_r[31:7]) * 51'(RECIP_DAY);

  always_ff @(posedge clk) begin
    ad2_r <= day_prod[50:35];
    u2_r  <= t1_r[31:7];
    lo2_r <= t1_r[6:0];
  end

  // ---------------------------------------------------------------- stage 3
  // Seconds of the day, rebuilt from the /675 remainder and the low 7 bits.
  assign rem675 = u2_r - 25'(ad2_r) * DAY_DIV;

  always_ff @(posedge clk) begin
    sod3_r <= {rem675[9:0], lo2_r};
  end

  // ---------------------------------------------------------------- stage 4
  assign hour_prod = 27'(sod3_r[16:4]) * 27'(RECIP_HOUR);

  always_ff @(posedge clk) begin
    hour4_r <= hour_prod[25:21];
    sod4_r  <= sod3_r;
  end

  // ---------------------------------------------------------------- stage 5
  always_ff @(posedge clk) begin
    soh5_r  <= 12'(sod4_r - 17'(hour4_r) * SECS_HOUR);
    hour5_r <= hour4_r;
  end

  // ---------------------------------------------------------------- stage 6
  assign min_prod = 21'(soh5_r[11:2]) * 21'(RECIP_MIN);

  always_ff @(posedge clk) begin
    min6_r  <= min_prod[19:14];
    soh6_r  <= soh5_r;
    hour6_r <= hour5_r;
  end

  // ---------------------------------------------------------------- stage 7
  always_ff @(posedge clk) begin
    sec7_r  <= 6'(soh6_r - 12'(min6_r) * SECS_MIN);
    min7_r  <= min6_r;
    hour7_r <= hour6_r;
  end

  // ---------------------------------------------------------------- stage 8
  // Time of day waits here for the date split to finish.
  always_ff @(posedge clk) begin
    sec8_r  <= sec7_r;
    min8_r  <= min7_r;
    hour8_r <= hour7_r;
  end

  // Date split runs stages 3..8 off the day count.
  esc_date_pipe u_date (
    .clk    (clk),
    .days_i (ad2_r),
    .date_o (date8)
  );

  // ---------------------------------------------------------------- stage 9
  always_ff @(posedge clk) begin
    out_micro_out   <= micro_r[8];
    out_before_base <= neg_r[8];
    if (neg_r[8]) begin
      out_year   <= '0;
      out_month  <= '0;
      out_day    <= '0;
      out_hour   <= '0;
      out_minute <= '0;
      out_second <= '0;
    end else begin
      out_year   <= date8.year;
      out_month  <= date8.month;
      out_day    <= date8.day;
      out_hour   <= hour8_r;
      out_minute <= min8_r;
      out_second <= sec8_r;
    end
  end

  // ---------------------------------------------------------------- checks
  `ESC_ASSERT_IMP(a_latency, accept, ##LATENCY out_valid,
    "accepted beat did not produce a result after the pipeline latency")

  `ESC_ASSERT_IMP(a_zero_before_base, out_valid && out_before_base,
    (out_year == 12'd0 && out_month == 4'd0 && out_day == 5'd0 &&
     out_hour == 5'd0 && out_minute == 6'd0 && out_second == 6'd0),
    "before-base result carries nonzero calendar fields")

  `ESC_ASSERT_IMP(a_field_range, out_valid && !out_before_base,
    (out_year >= 12'd2001 && out_month >= 4'd1 && out_month <= 4'd12 &&
     out_day >= 5'd1 && out_hour <= 5'd23 && out_minute <= 6'd59 &&
     out_second <= 6'd59),
    "calendar field out of range")

  `ESC_ASSERT_IMP(a_february, out_valid && !out_before_base && out_month == 4'd2,
    (out_day <= 5'd28 || (out_day == 5'd29 && out_year[1:0] == 2'b00)),
    "February day exceeds leap rule")

  `ESC_ASSERT_NXT(a_bias_track, cfg_wr, bias_r == zone_bias(zone_r),
    "zone bias out of step with zone register")

endmodule
